// ----- rtl/assert_macros.svh -----
// Assertion shorthands, all clocked on clk and disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant that holds at every edge.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/hss_pkg.sv -----
package hss_pkg;

  localparam int SET_DEPTH  = 256;
  localparam int COORD_BITS = 16;
  localparam int ADDR_BITS  = $clog2(SET_DEPTH);
  localparam int CNT_BITS   = $clog2(SET_DEPTH + 1);

  typedef enum logic [1:0] {
    FN_STAMP = 2'd0,
    FN_CLEAR = 2'd1,
    FN_READ  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    SHAPE_DISC = 2'd0,
    SHAPE_RING = 2'd1,
    SHAPE_ROW  = 2'd2,
    SHAPE_COL  = 2'd3
  } shape_t;

  typedef struct packed {
    logic [1:0]                   func;
    logic [1:0]                   mode;
    logic [3:0]                   radius;
    logic signed [COORD_BITS-1:0] center_q;
    logic signed [COORD_BITS-1:0] center_r;
    logic [7:0]                   read_index;
  } in_item_t;

  typedef struct packed {
    logic [CNT_BITS-1:0]          stored_count;
    logic                         dropped;
    logic                         entry_valid;
    logic signed [COORD_BITS-1:0] entry_q;
    logic signed [COORD_BITS-1:0] entry_r;
    logic [1:0]                   entry_mark;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] q;
    logic signed [COORD_BITS-1:0] r;
    logic [1:0]                   mark;
  } entry_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_BITS-1:0] waddr;
    entry_t               wdata;
    logic                 re;
    logic [ADDR_BITS-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic start;
    logic step;
  } walk_ctl_t;

  typedef struct packed {
    logic pass;
    logic last;
  } walk_sts_t;

endpackage

// ----- rtl/hss_chan_if.sv -----
interface hss_chan_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/hss_store.sv -----
module hss_store (
  input  logic              clk,
  input  hss_pkg::mem_req_t req,
  output hss_pkg::entry_t   rdata
);
  import hss_pkg::*;

  entry_t mem [SET_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end
endmodule

// ----- rtl/hss_walk.sv -----
module hss_walk #(
  parameter int MAX_RADIUS = 8
) (
  input  logic                                  clk,
  input  hss_pkg::walk_ctl_t                    ctl,
  input  logic [1:0]                            mode,
  input  logic [3:0]                            radius,
  input  logic signed [hss_pkg::COORD_BITS-1:0] center_q,
  input  logic signed [hss_pkg::COORD_BITS-1:0] center_r,
  output hss_pkg::walk_sts_t                    sts,
  output logic signed [hss_pkg::COORD_BITS-1:0] cell_q,
  output logic signed [hss_pkg::COORD_BITS-1:0] cell_r
);
  import hss_pkg::*;

  // radius magnitude bits; offsets and dq+dr need two more
  localparam int NW = $clog2(MAX_RADIUS + 2);
  localparam int OW = NW + 2;

  logic [NW-1:0]                n;
  logic [NW-1:0]                n_sat;
  logic [1:0]                   shape;
  logic signed [COORD_BITS-1:0] cq;
  logic signed [COORD_BITS-1:0] cr;
  logic signed [OW-1:0]         dq;
  logic signed [OW-1:0]         dr;
  logic signed [OW-1:0]         nn;
  logic signed [OW-1:0]         n_start;
  logic [OW-1:0]                aq;
  logic [OW-1:0]                ar;
  logic [OW-1:0]                as;
  logic [OW-1:0]                hex_dist;
  logic [OW-1:0]                nu;

  function automatic logic [OW-1:0] mag(input logic signed [OW-1:0] v);
    mag = (v < 0) ? OW'(-v) : OW'(v);
  endfunction

  assign n_sat   = (int'(radius) > MAX_RADIUS) ? NW'(MAX_RADIUS) : NW'(radius);
  assign n_start = signed'(OW'(n_sat));
  assign nn      = signed'(OW'(n));
  assign nu      = OW'(n);

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      n     <= n_sat;
      shape <= mode;
      cq    <= center_q;
      cr    <= center_r;
      dq    <= -n_start;
      dr    <= -n_start;
    end else if (ctl.step) begin
      if (dq == nn) begin
        dq <= -nn;
        dr <= dr + OW'(1);
      end else begin
        dq <= dq + OW'(1);
      end
    end
  end

  // hex distance as the largest of |dq|, |dr|, |dq+dr|
  always_comb begin
    aq       = mag(dq);
    ar       = mag(dr);
    as       = mag(dq + dr);
    hex_dist = aq;
    if (ar > hex_dist) hex_dist = ar;
    if (as > hex_dist) hex_dist = as;
  end

  always_comb begin
    sts.last = (dq == nn) && (dr == nn);
    unique case (shape)
      SHAPE_DISC: sts.pass = (hex_dist <= nu);
      SHAPE_RING: sts.pass = (hex_dist == nu);
      SHAPE_ROW:  sts.pass = (dr == 0);
      SHAPE_COL:  sts.pass = (dq == 0);
    endcase
  end

  assign cell_q   = cq + COORD_BITS'(dq);
  assign cell_r   = cr + COORD_BITS'(dr);
endmodule

// ----- rtl/hex_shape_stamp_set.sv -----
// Hex shape stamper with a duplicate-free cell set.
// in_ch (sink) takes commands: stamp a shape, clear the set, or read one entry.
// out_ch (source) gives exactly one result per command: the count after the
// command, the dropped flag of a stamp and, for a read, the entry fields.
// Commands are taken one at a time; in_ch is ready only while nothing is in work,
// but a finished result may still sit in the output register meanwhile.
// Work from transfer in to result valid:
//   clear or unused code: straight to the result; read: one store read;
//   stamp: (2n+1)^2 offset tests and, for each cell in the shape, one scan of the
//   stored entries through the single store read port.
//   At n = 8 a disc shape holds 217 cells.
// The duplicate scan sets the stamp rate: one stored entry is compared per cycle.
// Reset empties the set (count to zero) and drops any pending result; entry
// storage is not cleared, so no clearing pass is needed.
// A stalled receiver holds the result in the output register; a following
// command is still taken and finishes up to its result, then waits for the slot.
`include "assert_macros.svh"

module hex_shape_stamp_set #(
  parameter int MAX_RADIUS = 8
) (
  input  logic       clk,
  input  logic       rst,
  hss_chan_if.sink   in_ch,
  hss_chan_if.source out_ch
);
  import hss_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WALK  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_FETCH = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t                       state;
  logic [CNT_BITS-1:0]          count;
  logic [CNT_BITS-1:0]          addr;      // next scan address
  logic                         cmp_pend;  // read data due this cycle
  logic [ADDR_BITS-1:0]         cmp_idx;   // address of that read
  logic                         drop_flag;
  logic                         rd_ok;
  logic [1:0]                   mark;
  entry_t                       ent;
  out_item_t                    res;
  logic                         out_valid;

  logic                         accept;
  logic                         hit;
  logic                         scan_end;
  logic                         room;
  logic                         load;
  mem_req_t                     req;
  entry_t                       rdata;
  walk_ctl_t                    wctl;
  walk_sts_t                    wsts;
  logic signed [COORD_BITS-1:0] cell_q;
  logic signed [COORD_BITS-1:0] cell_r;

  hss_walk #(
    .MAX_RADIUS(MAX_RADIUS)
  ) u_walk (
    .clk      (clk),
    .ctl      (wctl),
    .mode     (in_ch.data.mode),
    .radius   (in_ch.data.radius),
    .center_q (in_ch.data.center_q),
    .center_r (in_ch.data.center_r),
    .sts      (wsts),
    .cell_q   (cell_q),
    .cell_r   (cell_r)
  );

  hss_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  assign in_ch.ready  = (state == S_IDLE);
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = res;

  // scan: one read issued per cycle, compared the cycle after
  assign hit      = cmp_pend && (rdata.q == cell_q) && (rdata.r == cell_r);
  assign scan_end = !hit && (addr == count);
  assign room     = (count < CNT_BITS'(SET_DEPTH));
  assign load     = (state == S_RESP) && (!out_valid || out_ch.ready);

  always_comb begin
    req.re = 1'b0;
    req.raddr = addr[ADDR_BITS-1:0];
    if (state == S_IDLE) begin
      req.re    = accept && (in_ch.data.func == FN_READ);
      req.raddr = in_ch.data.read_index[ADDR_BITS-1:0];
    end else if (state == S_SCAN) begin
      req.re = !hit && (addr != count);
    end
    // a hit rewrites the entry with the new mark; a miss appends if the set has room
    req.we         = (state == S_SCAN) && (hit || (scan_end && room));
    req.waddr      = hit ? cmp_idx : count[ADDR_BITS-1:0];
    req.wdata.q    = cell_q;
    req.wdata.r    = cell_r;
    req.wdata.mark = mark;
  end

  always_comb begin
    wctl.start = accept && (in_ch.data.func == FN_STAMP);
    wctl.step  = ((state == S_WALK) && !wsts.pass) ||
                 ((state == S_SCAN) && (hit || scan_end));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      cmp_pend  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            drop_flag <= 1'b0;
            rd_ok     <= 1'b0;
            ent       <= '0;
            mark      <= in_ch.data.mode;
            unique case (in_ch.data.func)
              FN_STAMP: state <= S_WALK;
              FN_CLEAR: begin
                count <= '0;
                state <= S_RESP;
              end
              FN_READ: begin
                rd_ok <= (CNT_BITS'(in_ch.data.read_index) < count);
                state <= S_FETCH;
              end
              default: state <= S_RESP;
            endcase
          end
        end
        S_WALK: begin
          if (wsts.pass) begin
            addr     <= '0;
            cmp_pend <= 1'b0;
            state    <= S_SCAN;
          end else if (wsts.last) begin
            state <= S_RESP;
          end
        end
        S_SCAN: begin
          if (hit || scan_end) begin
            cmp_pend <= 1'b0;
            if (scan_end) begin
              if (room) count <= count + CNT_BITS'(1);
              else drop_flag <= 1'b1;
            end
            state <= wsts.last ? S_RESP : S_WALK;
          end else begin
            cmp_pend <= 1'b1;
            cmp_idx  <= addr[ADDR_BITS-1:0];
            addr     <= addr + CNT_BITS'(1);
          end
        end
        S_FETCH: begin
          if (rd_ok) ent <= rdata;
          state <= S_RESP;
        end
        S_RESP: begin
          if (load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase

      if (load) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.stored_count <= count;
      res.dropped      <= drop_flag;
      res.entry_valid  <= rd_ok;
      res.entry_q      <= ent.q;
      res.entry_r      <= ent.r;
      res.entry_mark   <= ent.mark;
    end
  end

  `ASSERT_ALWAYS(a_count_bound, count <= CNT_BITS'(SET_DEPTH), "set count beyond depth")
  `ASSERT_IMPL(a_write_in_scan, req.we, state == S_SCAN, "store written outside scan")
  `ASSERT_IMPL(a_cmp_in_range, (state == S_SCAN) && cmp_pend,
               CNT_BITS'(cmp_idx) < count, "compare index beyond count")
  `ASSERT_NEXT(a_append_count, (state == S_SCAN) && scan_end && room,
               count == $past(count) + CNT_BITS'(1), "append did not bump count")
  `ASSERT_IMPL(a_drop_full, (state == S_SCAN) && scan_end && !room, !req.we,
               "write into a full set")
endmodule

// ----- tb/sv/hex_set_checker.sv -----
module hex_set_checker #(
  parameter int MAX_RADIUS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  logic               cmd_ready,
  input  hss_pkg::in_item_t  cmd_data,
  input  logic               res_valid,
  input  logic               res_ready,
  input  hss_pkg::out_item_t res_data,
  output int                 fail_count,
  output int                 pending,
  output int                 checked
);
  import hss_pkg::*;

  // Shadow copy of the cell set.
  entry_t              cells [SET_DEPTH];
  logic [CNT_BITS-1:0] cell_total;
  out_item_t           reports_due [$];

  function automatic int iabs(int v);
    return (v < 0) ? -v : v;
  endfunction

  // Returns 1 when a new cell finds the set full.
  function automatic bit insert_cell(logic [COORD_BITS-1:0] q, logic [COORD_BITS-1:0] r,
                                     logic [1:0] mark);
    for (int i = 0; i < cell_total; i++) begin
      if (cells[i].q == q && cells[i].r == r) begin
        cells[i].mark = mark;
        return 1'b0;
      end
    end
    if (cell_total < SET_DEPTH) begin
      cells[cell_total[ADDR_BITS-1:0]] = '{q: q, r: r, mark: mark};
      cell_total++;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic out_item_t run_set_command(in_item_t c);
    out_item_t res;
    int        n;
    int        hex_dist;
    bit        hit;
    res = '0;
    case (c.func)
      FN_STAMP: begin
        n = (c.radius > MAX_RADIUS) ? MAX_RADIUS : int'(c.radius);
        // row offset outer, column offset inner: this fixes the insertion order
        for (int dr = -n; dr <= n; dr++) begin
          for (int dq = -n; dq <= n; dq++) begin
            hex_dist = (iabs(dq) + iabs(dr) + iabs(dq + dr)) / 2;
            case (c.mode)
              SHAPE_DISC: hit = (hex_dist <= n);
              SHAPE_RING: hit = (hex_dist == n);
              SHAPE_ROW:  hit = (dr == 0);
              default:    hit = (dq == 0);
            endcase
            if (hit && insert_cell(COORD_BITS'(c.center_q + dq),
                                   COORD_BITS'(c.center_r + dr), c.mode))
              res.dropped = 1'b1;
          end
        end
      end
      FN_CLEAR: cell_total = '0;
      FN_READ: begin
        if (c.read_index < cell_total) begin
          res.entry_valid = 1'b1;
          res.entry_q     = cells[c.read_index].q;
          res.entry_r     = cells[c.read_index].r;
          res.entry_mark  = cells[c.read_index].mark;
        end
      end
      default: ;
    endcase
    res.stored_count = cell_total;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      cell_total = '0;
      reports_due.delete();
      fail_count = 0;
      checked    = 0;
    end else begin
      // results first: a result never belongs to a command taken at the same edge
      if (res_valid && res_ready) begin
        if (reports_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result, nothing outstanding: count %0d",
                     res_data.stored_count);
        end else begin
          want = reports_due.pop_front();
          checked++;
          if (res_data.stored_count !== want.stored_count ||
              res_data.dropped     !== want.dropped     ||
              res_data.entry_valid !== want.entry_valid ||
              res_data.entry_q     !== want.entry_q     ||
              res_data.entry_r     !== want.entry_r     ||
              res_data.entry_mark  !== want.entry_mark) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"result %0d mismatch (exp/got): count %0d/%0d dropped %b/%b ",
                        "valid %b/%b q %h/%h r %h/%h mark %0d/%0d"}, checked,
                       want.stored_count, res_data.stored_count,
                       want.dropped, res_data.dropped,
                       want.entry_valid, res_data.entry_valid,
                       want.entry_q, res_data.entry_q,
                       want.entry_r, res_data.entry_r,
                       want.entry_mark, res_data.entry_mark);
          end
        end
      end
      if (cmd_valid && cmd_ready)
        reports_due.push_back(run_set_command(cmd_data));
    end
    pending = reports_due.size();
  end

endmodule

// ----- tb/sv/tb_hex_shape_stamp_set.sv -----
module tb_hex_shape_stamp_set;
  import hss_pkg::*;

  localparam int STAMP_MAX_RADIUS = 8;
  // Worst single command is a radius-8 disc on a full set; the limit must cover
  // its whole run with no transfer on either channel.
  localparam int STALL_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 72;
  localparam int TAIL_CYCLES  = 20;
  // func code with no operation behind it
  localparam logic [1:0] FN_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hss_chan_if #(.payload_t(in_item_t))  cmd_ch ();
  hss_chan_if #(.payload_t(out_item_t)) res_ch ();

  int fail_count;
  int pending;
  int checked;
  int quiet;
  bit hold_req;
  bit hold_on;
  bit flood;
  int n_stamp, n_clear, n_read, n_spare;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  hex_shape_stamp_set #(.MAX_RADIUS(STAMP_MAX_RADIUS)) dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (cmd_ch.sink),
    .out_ch (res_ch.source)
  );

  hex_set_checker #(.MAX_RADIUS(STAMP_MAX_RADIUS)) u_check (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_ch.valid),
    .cmd_ready  (cmd_ch.ready),
    .cmd_data   (cmd_ch.data),
    .res_valid  (res_ch.valid),
    .res_ready  (res_ch.ready),
    .res_data   (res_ch.data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  // Watchdog: any transfer on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Idle length: mostly none, otherwise a random gap, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_item_t mk(logic [1:0] fn, logic [1:0] shape, logic [3:0] rad,
                                  logic [15:0] q, logic [15:0] r, logic [7:0] idx);
    in_item_t c;
    c.func       = fn;
    c.mode       = shape;
    c.radius     = rad;
    c.center_q   = q;
    c.center_r   = r;
    c.read_index = idx;
    return c;
  endfunction

  // Offer one command and hold it until the transfer. valid is only lowered
  // when a gap is wanted, so back-to-back commands keep it high throughout.
  task automatic push_cmd(input in_item_t c);
    int gap;
    gap = flood ? 0 : pick_gap();
    if (gap > 0) begin
      cmd_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.data  = c;
    cmd_ch.valid = 1'b1;
    do @(posedge clk); while (!cmd_ch.ready);
    case (c.func)
      FN_STAMP: n_stamp++;
      FN_CLEAR: n_clear++;
      FN_READ:  n_read++;
      default:  n_spare++;
    endcase
    @(negedge clk);
  endtask

  // Stop offering and let every outstanding result come back.
  task automatic drain_results();
    cmd_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Result side: bursts of ready with random gaps, the odd long clean burst,
  // and one long hold-off on request so the block backs up into its input.
  initial begin : result_sink
    int burst;
    int gap;
    res_ch.ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_on      = 1'b1;
        res_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_on = 1'b0;
      end
      burst = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      res_ch.ready = 1'b1;
      repeat (burst) @(negedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        res_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    in_item_t c;
    int       roll;
    int       spot;
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // --- directed part ---
    // read on an empty set, then the spare func code with every field at ones
    push_cmd(mk(FN_READ,  SHAPE_DISC, 4'd0,  16'h0000, 16'h0000, 8'd0));
    push_cmd(mk(FN_SPARE, SHAPE_COL,  4'd15, 16'hFFFF, 16'hFFFF, 8'd255));
    // single-cell shapes: disc and ring of radius zero
    push_cmd(mk(FN_STAMP, SHAPE_DISC, 4'd0,  16'h0000, 16'h0000, 8'd0));
    push_cmd(mk(FN_STAMP, SHAPE_RING, 4'd0,  16'h0005, 16'hFFFB, 8'd0));
    // radius over the limit saturates; centres at the coordinate extremes wrap
    push_cmd(mk(FN_STAMP, SHAPE_ROW,  4'd15, 16'h7FFF, 16'h8000, 8'd0));
    push_cmd(mk(FN_STAMP, SHAPE_COL,  4'd8,  16'h8000, 16'h7FFF, 8'd0));
    // overlapping shapes: duplicates only get their mark replaced
    push_cmd(mk(FN_STAMP, SHAPE_RING, 4'd3,  16'h0000, 16'h0000, 8'd0));
    push_cmd(mk(FN_STAMP, SHAPE_DISC, 4'd2,  16'h0000, 16'h0000, 8'd0));
    push_cmd(mk(FN_STAMP, SHAPE_DISC, 4'd1,  16'h0005, 16'hFFFB, 8'd0));
    push_cmd(mk(FN_READ,  SHAPE_DISC, 4'd0,  16'h0000, 16'h0000, 8'd0));
    push_cmd(mk(FN_READ,  SHAPE_DISC, 4'd0,  16'h0000, 16'h0000, 8'd1));
    push_cmd(mk(FN_READ,  SHAPE_DISC, 4'd0,  16'h0000, 16'h0000, 8'd40));
    push_cmd(mk(FN_READ,  SHAPE_DISC, 4'd0,  16'h0000, 16'h0000, 8'd255));
    // clear, then a read past the (now zero) count
    push_cmd(mk(FN_CLEAR, SHAPE_DISC, 4'd0,  16'h0000, 16'h0000, 8'd0));
    push_cmd(mk(FN_READ,  SHAPE_DISC, 4'd0,  16'h0000, 16'h0000, 8'd0));
    // fill the set: 217 cells, then a shifted disc overflows it
    push_cmd(mk(FN_STAMP, SHAPE_DISC, 4'd8,  16'h0000, 16'h0000, 8'd0));
    push_cmd(mk(FN_STAMP, SHAPE_DISC, 4'd8,  16'h0006, 16'hFFFD, 8'd0));
    push_cmd(mk(FN_READ,  SHAPE_DISC, 4'd0,  16'h0000, 16'h0000, 8'd255));
    // full set: stored cells still re-marked, no drop; all-new cells dropped
    push_cmd(mk(FN_STAMP, SHAPE_RING, 4'd1,  16'h0000, 16'h0000, 8'd0));
    push_cmd(mk(FN_STAMP, SHAPE_COL,  4'd15, 16'h0064, 16'h0064, 8'd0));
    push_cmd(mk(FN_READ,  SHAPE_DISC, 4'd0,  16'h0000, 16'h0000, 8'd128));
    push_cmd(mk(FN_CLEAR, SHAPE_DISC, 4'd0,  16'h0000, 16'h0000, 8'd0));

    // --- random part ---
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == 30) begin
        // long hold-off on the result side while commands keep coming
        hold_req = 1'b1;
        while (!hold_on) @(negedge clk);
        hold_req = 1'b0;
        flood    = 1'b1;
        for (int j = 0; j < 6; j++)
          push_cmd(mk(FN_READ, 2'($urandom()), 4'($urandom()), 16'($urandom()),
                      16'($urandom()), 8'($urandom_range(0, 31))));
      end
      if (k == 70) drain_results();
      // a stretch with no idling on the command side
      flood = (k >= 45 && k < 60);

      roll = $urandom_range(0, 99);
      c = mk(FN_STAMP, 2'($urandom()), 4'($urandom()), 16'($urandom()),
             16'($urandom()), 8'($urandom()));
      if (roll < 40) begin
        // big discs and rings are slow on a busy set, so keep most of them small
        if ((c.mode == SHAPE_DISC || c.mode == SHAPE_RING) && $urandom_range(0, 99) >= 6)
          c.radius = 4'($urandom_range(0, 3));
        spot = $urandom_range(0, 9);
        if (spot >= 4 && spot <= 8) begin
          // clustered centres so shapes overlap
          c.center_q = 16'($urandom_range(0, 40) - 20);
          c.center_r = 16'($urandom_range(0, 40) - 20);
        end else if (spot == 9) begin
          // straddle the wrap point
          c.center_q = 16'(16'h7FF8 + $urandom_range(0, 15));
          c.center_r = 16'(16'h7FF8 + $urandom_range(0, 15));
        end
      end else if (roll < 52) begin
        c.func = FN_CLEAR;
      end else if (roll < 95) begin
        c.func = FN_READ;
        if ($urandom_range(0, 99) < 60) c.read_index = 8'($urandom_range(0, 63));
      end else begin
        c.func = FN_SPARE;
      end
      push_cmd(c);
    end
    flood = 1'b0;

    // wind down: everything back, then a short tail for stray results
    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d stamps, %0d clears, %0d reads and %0d spare-code commands,",
             n_stamp, n_clear, n_read, n_spare);
    $display("including set overflow, coordinate wrap and a long result stall; %0d checked.",
             checked);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
